@@ hdl/pit3_pkg.sv @@
// ============================================================================
// pit3_pkg: shared definitions for the 3D point-in-triangle test
// Holds the default coordinate width, the stream widths, the failed-edge
// codes and the per-edge sign flags passed from the dot stage to the top.
// ============================================================================
package pit3_pkg;

    // Default coordinate width for every point and vertex field.
    localparam int COORD_WIDTH_DEF = 16;

    // Coordinates per input transaction: point, A, B, C, each x/y/z.
    localparam int NUM_COORDS = 12;

    // Result transaction: inside_res (1 bit) and failed_edge (2 bits).
    localparam int OUT_FIELD_W = 3;
    localparam int OUT_TDATA_W = 8;

    // Codes for the first edge whose dot product came out negative.
    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_AB   = 2'd1;
    localparam logic [1:0] EDGE_BC   = 2'd2;
    localparam logic [1:0] EDGE_CA   = 2'd3;

    // Sign of each edge dot product, set when the dot is negative.
    typedef struct packed {
        logic ca;
        logic bc;
        logic ab;
    } edge_neg_t;

endpackage

@@ hdl/point_in_triangle_3d_test.sv @@
// ============================================================================
// point_in_triangle_3d_test: same-side point-in-triangle test in 3D
// Forms the plane normal (C-A)x(B-A) and, for edges AB, BC and CA, dots the
// edge cross product with it. The first negative dot marks the point outside.
//
//   Channel   Direction  Handshake               Content
//   s_axis    in         s_axis_tvalid/tready    point and vertices A, B, C
//   m_axis    out        m_axis_tvalid/tready    inside flag, first failed edge
//
// One transaction is accepted per cycle unless the output stalls; each result
// passes the difference, two cross, three dot and one output stage in turn.
// Every stage holds a valid bit and loads when empty or when the next stage
// loads, so bubbles are squeezed out and a stall loses nothing.
// Reset clears all valid bits; the block keeps no state between transactions.
// ============================================================================
module point_in_triangle_3d_test #(
    parameter int  COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((pit3_pkg::NUM_COORDS * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0 up: point_x, point_y, point_z, a_x, a_y, a_z,
    // b_x, b_y, b_z, c_x, c_y, c_z, zero fill to a whole byte.
    input  logic [IN_TDATA_W-1:0]              s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0 up: inside_res, failed_edge[1:0], zero fill.
    output logic [pit3_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import pit3_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int XW = 2 * DW + 1;

    logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] coords;
    logic [3:0][2:0][DW-1:0] u_vec;
    logic [3:0][2:0][DW-1:0] v_vec;
    logic [3:0][2:0][XW-1:0] x_vec;
    logic                    diff_valid;
    logic                    diff_ready;
    logic                    cross_valid;
    logic                    cross_ready;
    logic                    dot_valid;
    logic                    dot_ready;
    edge_neg_t               edge_neg;
    logic [1:0]              failed_next;
    logic                    inside_next;
    logic [1:0]              failed_reg;
    logic                    inside_reg;
    logic                    out_valid_reg;

    assign coords = s_axis_tdata[NUM_COORDS*COORD_WIDTH-1:0];

    pit3_diff #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_diff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .coords    (coords),
        .out_valid (diff_valid),
        .out_ready (diff_ready),
        .u_vec     (u_vec),
        .v_vec     (v_vec)
    );

    pit3_cross #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (diff_valid),
        .in_ready  (diff_ready),
        .u_vec     (u_vec),
        .v_vec     (v_vec),
        .out_valid (cross_valid),
        .out_ready (cross_ready),
        .x_vec     (x_vec)
    );

    pit3_dot #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cross_valid),
        .in_ready  (cross_ready),
        .x_vec     (x_vec),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .edge_neg  (edge_neg)
    );

    // The output register loads when empty or when its result is taken.
    assign dot_ready = !out_valid_reg || m_axis_tready;

    // Report the first edge, in the order AB, BC, CA, with a negative dot.
    always_comb
    begin
        if (edge_neg.ab)
        begin
            failed_next = EDGE_AB;
        end
        else if (edge_neg.bc)
        begin
            failed_next = EDGE_BC;
        end
        else if (edge_neg.ca)
        begin
            failed_next = EDGE_CA;
        end
        else
        begin
            failed_next = EDGE_NONE;
        end
        inside_next = (failed_next == EDGE_NONE);
    end

    // Output valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (dot_ready)
        begin
            out_valid_reg <= dot_valid;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        if (dot_ready)
        begin
            failed_reg <= failed_next;
            inside_reg <= inside_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, failed_reg, inside_reg};

endmodule

@@ hdl/pit3_diff.sv @@
// ============================================================================
// pit3_diff: vertex difference stage
// Sign-extends the twelve coordinates and forms the operand vectors of the
// four cross products: the plane normal and one per triangle edge.
// ============================================================================
module pit3_diff #(
    parameter int COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_ready,
    input  logic [pit3_pkg::NUM_COORDS-1:0][COORD_WIDTH-1:0] coords,
    output logic                                       out_valid,
    input  logic                                       out_ready,
    output logic [3:0][2:0][COORD_WIDTH:0]             u_vec,
    output logic [3:0][2:0][COORD_WIDTH:0]             v_vec
);
    import pit3_pkg::*;

    localparam int DW = COORD_WIDTH + 1;

    logic signed [DW-1:0]  p_ext [3];
    logic signed [DW-1:0]  a_ext [3];
    logic signed [DW-1:0]  b_ext [3];
    logic signed [DW-1:0]  c_ext [3];
    logic [3:0][2:0][DW-1:0] u_next;
    logic [3:0][2:0][DW-1:0] v_next;
    logic [3:0][2:0][DW-1:0] u_reg;
    logic [3:0][2:0][DW-1:0] v_reg;
    logic                  valid_reg;
    logic                  load;

    // The stage takes a new transaction when empty or when it drains.
    assign load     = !valid_reg || out_ready;
    assign in_ready = load;

    // Sign-extend each coordinate by one bit so that differences are exact.
    for (genvar i = 0; i < 3; i++) begin : g_ext
        assign p_ext[i] = DW'($signed(coords[i]));
        assign a_ext[i] = DW'($signed(coords[3 + i]));
        assign b_ext[i] = DW'($signed(coords[6 + i]));
        assign c_ext[i] = DW'($signed(coords[9 + i]));
    end

    // Cross operands: normal (C-A)x(B-A), then (A-B)x(P-B), (B-C)x(P-C),
    // and (C-A)x(P-A) for the edges AB, BC and CA.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_next[0][i] = c_ext[i] - a_ext[i];
            v_next[0][i] = b_ext[i] - a_ext[i];
            u_next[1][i] = a_ext[i] - b_ext[i];
            v_next[1][i] = p_ext[i] - b_ext[i];
            u_next[2][i] = b_ext[i] - c_ext[i];
            v_next[2][i] = p_ext[i] - c_ext[i];
            u_next[3][i] = c_ext[i] - a_ext[i];
            v_next[3][i] = p_ext[i] - a_ext[i];
        end
    end

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload of the stage.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            u_reg <= u_next;
            v_reg <= v_next;
        end
    end

    assign out_valid = valid_reg;
    assign u_vec     = u_reg;
    assign v_vec     = v_reg;

endmodule

@@ hdl/pit3_cross.sv @@
// ============================================================================
// pit3_cross: cross product stages
// Two register stages: the first forms the 24 component products of the
// four cross products, the second subtracts them pairwise.
// ============================================================================
module pit3_cross #(
    parameter int COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [3:0][2:0][COORD_WIDTH:0]       u_vec,
    input  logic [3:0][2:0][COORD_WIDTH:0]       v_vec,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [3:0][2:0][2*COORD_WIDTH+2:0]   x_vec
);
    import pit3_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int PW = 2 * DW;
    localparam int XW = PW + 1;

    logic signed [PW-1:0]    pa_next [4][3];
    logic signed [PW-1:0]    pb_next [4][3];
    logic signed [PW-1:0]    pa_reg  [4][3];
    logic signed [PW-1:0]    pb_reg  [4][3];
    logic [3:0][2:0][XW-1:0] x_next;
    logic [3:0][2:0][XW-1:0] x_reg;
    logic                    va_reg;
    logic                    vb_reg;
    logic                    load_a;
    logic                    load_b;

    // Each stage loads when empty or when the stage after it loads.
    assign load_b   = !vb_reg || out_ready;
    assign load_a   = !va_reg || load_b;
    assign in_ready = load_a;

    // Component products: out[j] = u[j+1]*v[j+2] - u[j+2]*v[j+1].
    for (genvar k = 0; k < 4; k++) begin : g_vec
        for (genvar j = 0; j < 3; j++) begin : g_comp
            localparam int J1 = (j + 1) % 3;
            localparam int J2 = (j + 2) % 3;
            assign pa_next[k][j] = $signed(u_vec[k][J1]) * $signed(v_vec[k][J2]);
            assign pb_next[k][j] = $signed(u_vec[k][J2]) * $signed(v_vec[k][J1]);
            assign x_next[k][j]  = XW'(pa_reg[k][j]) - XW'(pb_reg[k][j]);
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (load_a)
            begin
                va_reg <= in_valid;
            end
            if (load_b)
            begin
                vb_reg <= va_reg;
            end
        end
    end

    // Product registers.
    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    // Cross product registers.
    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            x_reg <= x_next;
        end
    end

    assign out_valid = vb_reg;
    assign x_vec     = x_reg;

endmodule

@@ hdl/pit3_dot.sv @@
// ============================================================================
// pit3_dot: edge dot product stages
// Dots each edge cross product with the plane normal. Every wide product is
// split into four partial products in the first stage, assembled in the
// second, and the three terms are summed for their sign in the third.
// ============================================================================
module pit3_dot #(
    parameter int COORD_WIDTH = pit3_pkg::COORD_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [3:0][2:0][2*COORD_WIDTH+2:0]   x_vec,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output pit3_pkg::edge_neg_t                  edge_neg
);
    import pit3_pkg::*;

    localparam int XW = 2 * COORD_WIDTH + 3;
    localparam int L  = (XW + 1) / 2;
    localparam int H  = XW - L;
    localparam int MW = H + L + 1;
    localparam int FW = 2 * XW;
    localparam int SW = FW + 2;

    logic signed [2*H-1:0] hh_next [3][3];
    logic signed [MW-1:0]  hl_next [3][3];
    logic signed [MW-1:0]  lh_next [3][3];
    logic [2*L-1:0]        ll_next [3][3];
    logic signed [2*H-1:0] hh_reg  [3][3];
    logic signed [MW-1:0]  hl_reg  [3][3];
    logic signed [MW-1:0]  lh_reg  [3][3];
    logic [2*L-1:0]        ll_reg  [3][3];
    logic signed [FW-1:0]  prod_next [3][3];
    logic signed [FW-1:0]  prod_reg  [3][3];
    logic signed [SW-1:0]  sum_dot [3];
    logic [2:0]            neg_bits;
    edge_neg_t             neg_next;
    edge_neg_t             neg_reg;
    logic                  va_reg;
    logic                  vb_reg;
    logic                  vc_reg;
    logic                  load_a;
    logic                  load_b;
    logic                  load_c;

    // Each stage loads when empty or when the stage after it loads.
    assign load_c   = !vc_reg || out_ready;
    assign load_b   = !vb_reg || load_c;
    assign load_a   = !va_reg || load_b;
    assign in_ready = load_a;

    // Partial products of normal[i] * edge_cross[i], split at bit L.
    for (genvar e = 0; e < 3; e++) begin : g_edge
        for (genvar i = 0; i < 3; i++) begin : g_comp
            logic signed [H-1:0] n_hi;
            logic signed [H-1:0] c_hi;
            logic signed [L:0]   n_lo_s;
            logic signed [L:0]   c_lo_s;

            assign n_hi   = $signed(x_vec[0][i][XW-1:L]);
            assign c_hi   = $signed(x_vec[e + 1][i][XW-1:L]);
            assign n_lo_s = $signed({1'b0, x_vec[0][i][L-1:0]});
            assign c_lo_s = $signed({1'b0, x_vec[e + 1][i][L-1:0]});

            assign hh_next[e][i] = n_hi * c_hi;
            assign hl_next[e][i] = n_hi * c_lo_s;
            assign lh_next[e][i] = n_lo_s * c_hi;
            assign ll_next[e][i] = x_vec[0][i][L-1:0] * x_vec[e + 1][i][L-1:0];

            // Reassemble the full product from its partial products.
            assign prod_next[e][i] = (FW'(hh_reg[e][i]) <<< (2 * L))
                                   + ((FW'(hl_reg[e][i]) + FW'(lh_reg[e][i])) <<< L)
                                   + $signed({{(FW - 2 * L){1'b0}}, ll_reg[e][i]});
        end

        // Sum the three terms and keep only the sign.
        assign sum_dot[e]  = SW'(prod_reg[e][0]) + SW'(prod_reg[e][1])
                           + SW'(prod_reg[e][2]);
        assign neg_bits[e] = sum_dot[e][SW-1];
    end

    assign neg_next.ab = neg_bits[0];
    assign neg_next.bc = neg_bits[1];
    assign neg_next.ca = neg_bits[2];

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else
        begin
            if (load_a)
            begin
                va_reg <= in_valid;
            end
            if (load_b)
            begin
                vb_reg <= va_reg;
            end
            if (load_c)
            begin
                vc_reg <= vb_reg;
            end
        end
    end

    // Partial product registers.
    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            hh_reg <= hh_next;
            hl_reg <= hl_next;
            lh_reg <= lh_next;
            ll_reg <= ll_next;
        end
    end

    // Full product registers.
    always_ff @(posedge clk)
    begin
        if (load_b)
        begin
            prod_reg <= prod_next;
        end
    end

    // Sign flag registers.
    always_ff @(posedge clk)
    begin
        if (load_c)
        begin
            neg_reg <= neg_next;
        end
    end

    assign out_valid = vc_reg;
    assign edge_neg  = neg_reg;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: stream testbench for the 3D point-in-triangle test
// Feeds point and triangle transactions into the block, predicts the inside
// flag and the first failing edge with exact wide arithmetic, and compares
// every result transaction in order under random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import pit3_pkg::*;

    localparam int COORD_W     = COORD_WIDTH_DEF;
    localparam int IN_W        = ((NUM_COORDS * COORD_W + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 444;
    localparam int DRAIN_CYCLES = 16;
    localparam int LIMIT_CYCLES = 200000;

    // One query: coordinate i sits at bits [16*i +: 16], in the order
    // point x/y/z, A x/y/z, B x/y/z, C x/y/z.
    typedef logic [NUM_COORDS-1:0][COORD_W-1:0] query_t;

    // A vector at full predictor width.
    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } vec_t;

    // Expected contents of one result transaction.
    typedef struct {
        logic       inside_flag;
        logic [1:0] edge_code;
    } verdict_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts each accepted query and checks results in order.
    // ------------------------------------------------------------------------
    class triangle_scoreboard;
        verdict_t pending[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function vec_t vec_at(query_t q, int base);
            vec_t r;
            r.x = longint'($signed(q[base]));
            r.y = longint'($signed(q[base + 1]));
            r.z = longint'($signed(q[base + 2]));
            return r;
        endfunction

        function vec_t vsub(vec_t u, vec_t v);
            vec_t r;
            r.x = u.x - v.x;
            r.y = u.y - v.y;
            r.z = u.z - v.z;
            return r;
        endfunction

        // Components stay near 35 bits, so 64-bit products are exact here.
        function vec_t vcross(vec_t u, vec_t v);
            vec_t r;
            r.x = u.y * v.z - u.z * v.y;
            r.y = u.z * v.x - u.x * v.z;
            r.z = u.x * v.y - u.y * v.x;
            return r;
        endfunction

        // The dot product needs about 72 bits; it is summed at 128 bits.
        function bit dot_negative(vec_t u, vec_t v);
            logic signed [127:0] ux, uy, uz, vx, vy, vz, s;
            ux = u.x;
            uy = u.y;
            uz = u.z;
            vx = v.x;
            vy = v.y;
            vz = v.z;
            s = ux * vx + uy * vy + uz * vz;
            return s[127];
        endfunction

        // Crosses the edge vector (head - tail) with (p - tail), dots with n.
        function bit edge_negative(vec_t n, vec_t head, vec_t tail, vec_t p);
            return dot_negative(n, vcross(vsub(head, tail), vsub(p, tail)));
        endfunction

        function logic [1:0] first_failed_edge(query_t q);
            vec_t p, a, b, c, n;
            p = vec_at(q, 0);
            a = vec_at(q, 3);
            b = vec_at(q, 6);
            c = vec_at(q, 9);
            n = vcross(vsub(c, a), vsub(b, a));
            if (edge_negative(n, a, b, p))
                return EDGE_AB;
            else if (edge_negative(n, b, c, p))
                return EDGE_BC;
            else if (edge_negative(n, c, a, p))
                return EDGE_CA;
            return EDGE_NONE;
        endfunction

        function void note_query(query_t q);
            verdict_t v;
            v.edge_code   = first_failed_edge(q);
            v.inside_flag = (v.edge_code == EDGE_NONE);
            pending.push_back(v);
        endfunction

        function void report(string what, int expected, int actual);
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH at %0t: %s expected %0d actual %0d",
                         $realtime, what, expected, actual);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata);
            verdict_t v;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH at %0t: result 0x%0h with none pending",
                             $realtime, tdata);
                return;
            end
            v = pending.pop_front();
            if (tdata[0] !== v.inside_flag)
                report("inside_res", v.inside_flag, tdata[0]);
            if (tdata[2:1] !== v.edge_code)
                report("failed_edge", v.edge_code, tdata[2:1]);
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    triangle_scoreboard sb;
    int                 tx_idle_pct;
    int                 rx_idle_pct;
    int                 cycles;

    point_in_triangle_3d_test #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Clock generation.
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // The receiver stalls at random, decided at each falling edge.
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Check every result transaction at the rising edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [COORD_W-1:0] clamp_coord(longint v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return v[COORD_W-1:0];
    endfunction

    function automatic longint rand_between(int lo, int hi);
        return longint'(lo) + longint'($urandom_range(0, hi - lo));
    endfunction

    function automatic query_t tri_query(int px, int py, int pz, int ax, int ay, int az,
                                         int bx, int by, int bz, int cx, int cy, int cz);
        query_t q;
        q[0]  = px[COORD_W-1:0];
        q[1]  = py[COORD_W-1:0];
        q[2]  = pz[COORD_W-1:0];
        q[3]  = ax[COORD_W-1:0];
        q[4]  = ay[COORD_W-1:0];
        q[5]  = az[COORD_W-1:0];
        q[6]  = bx[COORD_W-1:0];
        q[7]  = by[COORD_W-1:0];
        q[8]  = bz[COORD_W-1:0];
        q[9]  = cx[COORD_W-1:0];
        q[10] = cy[COORD_W-1:0];
        q[11] = cz[COORD_W-1:0];
        return q;
    endfunction

    // Random query generator, weighted toward points near or inside the
    // triangle so that every edge outcome and the zero-dot cases show up.
    function automatic query_t random_query();
        query_t q;
        longint wa, wb, wc, wsum, d, acc;
        int     kind, axis, pick, sel;
        int     extremes[7];
        extremes = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            // Raw noise over the whole coordinate range.
            for (int i = 0; i < NUM_COORDS; i++)
                q[i] = COORD_W'($urandom());
        end else if (kind < 55) begin
            // Weighted combination of the vertices, sometimes slightly off.
            for (int i = 3; i < NUM_COORDS; i++)
                q[i] = COORD_W'($urandom());
            wa = rand_between(-20, 300);
            wb = rand_between(-20, 300);
            wc = rand_between(-20, 300);
            wsum = wa + wb + wc;
            if (wsum <= 0) begin
                wa = 1;
                wsum = wb + wc + 1;
                if (wsum <= 0) begin
                    wb = 0;
                    wc = 0;
                    wsum = 1;
                end
            end
            for (axis = 0; axis < 3; axis++) begin
                acc = wa * longint'($signed(q[3 + axis]))
                    + wb * longint'($signed(q[6 + axis]))
                    + wc * longint'($signed(q[9 + axis]));
                acc = acc / wsum;
                if ($urandom_range(0, 1))
                    acc = acc + rand_between(-2, 2);
                q[axis] = clamp_coord(acc);
            end
        end else if (kind < 70) begin
            // Tiny coordinates: frequent zero dots and flat triangles.
            for (int i = 0; i < NUM_COORDS; i++)
                q[i] = clamp_coord(rand_between(-3, 3));
        end else if (kind < 80) begin
            // Collinear or coincident vertices.
            for (axis = 0; axis < 3; axis++) begin
                q[axis]     = COORD_W'($urandom());
                acc         = rand_between(-10000, 10000);
                d           = ($urandom_range(0, 2) == 0) ? 0 : rand_between(-5000, 5000);
                q[3 + axis] = clamp_coord(acc);
                q[6 + axis] = clamp_coord(acc + d);
                q[9 + axis] = clamp_coord(acc + d * rand_between(-2, 2));
            end
        end else if (kind < 90) begin
            // Point on an edge midpoint or on a vertex; even vertex
            // coordinates keep the midpoint exact.
            for (int i = 3; i < NUM_COORDS; i++)
                q[i] = clamp_coord(2 * rand_between(-16384, 16383));
            pick = $urandom_range(0, 5);
            for (axis = 0; axis < 3; axis++) begin
                case (pick)
                    0: acc = (longint'($signed(q[3 + axis]))
                            + longint'($signed(q[6 + axis]))) / 2;
                    1: acc = (longint'($signed(q[6 + axis]))
                            + longint'($signed(q[9 + axis]))) / 2;
                    2: acc = (longint'($signed(q[9 + axis]))
                            + longint'($signed(q[3 + axis]))) / 2;
                    3: acc = longint'($signed(q[3 + axis]));
                    4: acc = longint'($signed(q[6 + axis]));
                    default: acc = longint'($signed(q[9 + axis]));
                endcase
                q[axis] = clamp_coord(acc);
            end
        end else begin
            // Coordinates at and next to the range limits.
            for (int i = 0; i < NUM_COORDS; i++) begin
                sel = $urandom_range(0, 6);
                q[i] = clamp_coord(extremes[sel]);
            end
        end
        return q;
    endfunction

    // Present one query and hold it until the block accepts it.
    task automatic send_query(query_t q);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= q;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_query(q);
        @(negedge clk);
    endtask

    // Hold the input side idle until every expected result has arrived.
    task automatic wait_all_results();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending.size() != 0);
    endtask

    // Stimulus sequence.
    initial
    begin
        query_t directed[$];
        sb            = new();
        cycles        = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        tx_idle_pct   = 38;
        rx_idle_pct   = 54;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed transactions: extremes, flat triangles, each edge side,
        // points on edges and vertices, and both windings.
        directed.push_back(tri_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(tri_query(32767, 32767, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(tri_query(-32768, -32768, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768, -32768, -32768));
        directed.push_back(tri_query(0, -10923, 0, -32768, -32768, -32768,
                                     32767, -32768, 0, 0, 32767, 32767));
        directed.push_back(tri_query(32767, 32767, 32767, -32768, -32768, -32768,
                                     32767, -32768, 0, 0, 32767, 32767));
        directed.push_back(tri_query(-32768, 32767, -32768, -32768, -32768, -32768,
                                     32767, -32768, 0, 0, 32767, 32767));
        directed.push_back(tri_query(0, -32768, 32767, -32768, -32768, -32768,
                                     32767, -32768, 0, 0, 32767, 32767));
        directed.push_back(tri_query(20, 20, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(20, 20, 5000, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(50, -50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(100, 100, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(-50, 50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(-50, -50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(200, -50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(50, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(0, 0, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(50, 50, 0, 0, 0, 0, 100, 0, 0, 0, 100, 0));
        directed.push_back(tri_query(50, -50, 0, 0, 0, 0, 0, 100, 0, 100, 0, 0));
        directed.push_back(tri_query(-50, 50, 0, 0, 0, 0, 0, 100, 0, 100, 0, 0));
        directed.push_back(tri_query(5, -7, 3, 0, 0, 0, 10, 10, 10, 20, 20, 20));
        directed.push_back(tri_query(1, 1, 1, 7, -3, 2, 7, -3, 2, 100, 50, -20));
        foreach (directed[i])
            send_query(directed[i]);

        // Random phases with shifting stall patterns on the two sides.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 38; rx_idle_pct = 54; end
                1: begin tx_idle_pct = 54; rx_idle_pct = 38; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int i = 0; i < RANDOM_ITEMS; i++)
                send_query(random_query());
            if (phase == 0)
                wait_all_results();
        end

        // Drain the pipeline, then let the clock run on before the final report.
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
